>>> design/tdpt_pkg.sv
// Package: widths and constants shared by the trial-division prime tester.
package tdpt_pkg;

	// Width of the candidate value.
	localparam int VALUE_WIDTH = 16;

	// Divisor width: holds one past floor(sqrt(2^VALUE_WIDTH - 1)).
	localparam int D_W = (VALUE_WIDTH + 1) / 2 + 1;

	// Width of the running divisor square.
	localparam int SQ_W = 2 * D_W;

	// Bit counter of the serial remainder unit.
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	// Smallest prime, also the first trial divisor.
	localparam int MIN_PRIME = 2;

endpackage

>>> design/trial_division_prime_test_top.sv
// Top level: trial-division primality tester with a shared bit-serial remainder unit.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in      | in  | in_valid / in_stall  | candidate [VALUE_WIDTH-1:0] unsigned
//  out     | out | out_valid / out_stall| prime_flag (1 = prime)
//
// Each divisor d = 2, 3, ... takes one square test followed by a pass of the
// restoring remainder unit (one candidate bit per cycle); the search stops
// at the first exact divisor or once d*d passes the candidate.
// in_stall is high from the accepted beat until the verdict enters the output
// register, which holds it while out_stall is high. Reset clears control only.
module trial_division_prime_test_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             prime_flag
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                           state_q;
	logic [tdpt_pkg::VALUE_WIDTH-1:0] cand_q;   // candidate under test
	logic [tdpt_pkg::VALUE_WIDTH-1:0] shift_q;  // candidate bits fed MSB first
	logic [tdpt_pkg::D_W-1:0]         d_q;      // current trial divisor
	logic [tdpt_pkg::SQ_W-1:0]        sq_q;     // d_q * d_q, kept incrementally
	logic [tdpt_pkg::D_W-1:0]         rem_q;    // partial remainder
	logic [tdpt_pkg::CNT_W-1:0]       cnt_q;    // bits left in this division, minus one
	logic                             verdict_q;
	logic                             out_valid_q;
	logic                             flag_q;

	// Shared remainder step: bring in one candidate bit, subtract d if it fits.
	logic [tdpt_pkg::D_W:0]   trial;
	logic                     fits;
	logic [tdpt_pkg::D_W-1:0] rem_next;

	assign trial    = {rem_q, shift_q[tdpt_pkg::VALUE_WIDTH-1]};
	assign fits     = trial >= {1'b0, d_q};
	assign rem_next = fits ? tdpt_pkg::D_W'(trial - {1'b0, d_q})
	                       : tdpt_pkg::D_W'(trial);

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign prime_flag = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			verdict_q   <= 1'b0;
			flag_q      <= 1'b0;
		end else begin
			// Finish state reloads the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (candidate < tdpt_pkg::VALUE_WIDTH'(tdpt_pkg::MIN_PRIME)) begin
							verdict_q <= 1'b0;
							state_q   <= ST_FINISH;
						end else begin
							state_q <= ST_TEST;
						end
					end
				end
				ST_TEST: begin
					// No divisor up to sqrt(candidate) found: prime.
					if (sq_q > tdpt_pkg::SQ_W'(cand_q)) begin
						verdict_q <= 1'b1;
						state_q   <= ST_FINISH;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (rem_next == '0) begin
							verdict_q <= 1'b0;
							state_q   <= ST_FINISH;
						end else begin
							state_q <= ST_TEST;
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						flag_q      <= verdict_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the search; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cand_q <= candidate;
				d_q    <= tdpt_pkg::D_W'(tdpt_pkg::MIN_PRIME);
				sq_q   <= tdpt_pkg::SQ_W'(tdpt_pkg::MIN_PRIME * tdpt_pkg::MIN_PRIME);
			end
			ST_TEST: begin
				shift_q <= cand_q;
				rem_q   <= '0;
				cnt_q   <= tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_WIDTH - 1);
			end
			ST_DIV: begin
				rem_q   <= rem_next;
				shift_q <= {shift_q[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
				cnt_q   <= cnt_q - tdpt_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					// (d+1)^2 = d^2 + 2d + 1
					sq_q <= sq_q + (tdpt_pkg::SQ_W'(d_q) << 1) + tdpt_pkg::SQ_W'(1);
					d_q  <= d_q + tdpt_pkg::D_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Running square must track the divisor at every test.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEST |-> sq_q == tdpt_pkg::SQ_W'(d_q) * tdpt_pkg::SQ_W'(d_q))
		else $error("divisor square out of step");

	// Partial remainder stays below the divisor during division.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < d_q)
		else $error("partial remainder not below divisor");

	// A new verdict only comes out of the finish state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result beat without finished search");

	// A prime verdict never goes with a divisor that was tested too early.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && verdict_q |-> sq_q > tdpt_pkg::SQ_W'(cand_q))
		else $error("prime verdict before square bound reached");

endmodule
